// ===== design/plist_pkg.sv =====
// Shared constants, codes and cell control types for the positional list engine.
package plist_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;

  // Registered levels in the read-out OR tree.
  localparam int TREE_LVLS = 3;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_READ
  } cell_op_t;

  // Broadcast to every cell; tgt is the zero-based target position.
  typedef struct packed {
    cell_op_t            op;
    logic [POS_W-1:0]    tgt;
    logic [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage

// ===== design/positional_list_engine_core.sv =====
// Positional list engine top level: command sequencer, cell row and read-out tree.
//
// done rises once the command has passed through the cell row and the read-out tree: the whole
// cell row inserts, removes or captures the addressed entry at once, and the registered OR tree
// then brings a read entry out of the row. busy is high from the start transfer until the cycle
// in which done is high, so a new command may be started in the done cycle. done marks read_value,
// status and length for exactly one cycle and cannot be held off by the receiver.
// After reset the list is empty; no clearing pass is needed.
module positional_list_engine_core import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] read_value,
  output logic [1:0]               status,
  output logic [LEN_W-1:0]         length
);

  localparam int IW = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
  localparam int DW = $clog2(TREE_LVLS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  state_t            state;
  logic [1:0]        cmd_func;
  logic [POS_W-1:0]  cmd_pos;
  logic [DATA_W-1:0] cmd_value;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DW-1:0]     drain;
  logic [1:0]        status_c;
  cell_op_t          op_c;
  cell_ctl_t         ctl;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic              pos_zero;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] tree_root;

  assign pos_x    = XW'(cmd_pos);
  assign cnt_x    = XW'(count);
  assign pos_zero = (cmd_pos == '0);

  // Decide the command against the current length.
  always_comb begin
    status_c   = ST_OK;
    op_c       = CELL_HOLD;
    count_next = count;
    case (cmd_func)
      FN_INSERT: begin
        if (pos_zero || pos_x > cnt_x + XW'(1)) begin
          status_c = ST_BAD_POS;
        end else if (cnt_x == CAP_X) begin
          status_c = ST_FULL;
        end else begin
          op_c       = CELL_INS;
          count_next = count + CW'(1);
        end
      end
      FN_READ: begin
        if (pos_zero || pos_x > cnt_x) begin
          status_c = ST_BAD_POS;
        end else begin
          op_c = CELL_READ;
        end
      end
      FN_REMOVE: begin
        if (pos_zero || pos_x > cnt_x) begin
          status_c = ST_BAD_POS;
        end else begin
          op_c       = CELL_DEL;
          count_next = count - CW'(1);
        end
      end
      default: begin
        status_c = ST_BAD_POS;
      end
    endcase
  end

  always_comb begin
    ctl.op    = (state == S_EXEC) ? op_c : CELL_HOLD;
    ctl.tgt   = cmd_pos - POS_W'(1);
    ctl.value = cmd_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
      drain  <= '0;
      status <= ST_OK;
      length <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_func  <= func;
            cmd_pos   <= position;
            cmd_value <= value;
            busy      <= 1'b1;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          count  <= count_next;
          status <= status_c;
          length <= LEN_W'(count_next);
          drain  <= DW'(TREE_LVLS - 1);
          state  <= S_DRAIN;
        end
        S_DRAIN: begin
          // Wait for the read-out tree to deliver the captured entry.
          if (drain == '0) begin
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            drain <= drain - DW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    plist_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  plist_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_rd),
    .root (tree_root)
  );

  assign read_value = $signed(tree_root);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a command in flight");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted command did not raise busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> read_value == '0)
    else $error("failed command returned a nonzero value");

endmodule

// ===== design/plist_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, masks its entry onto the read-out.
module plist_cell import plist_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = POS_W
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [IW-1:0] tgt_x;
  logic          hit;
  logic          above;

  assign tgt_x = IW'(ctl.tgt);
  assign hit   = (MY_IDX == tgt_x);
  assign above = (MY_IDX > tgt_x);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INS: begin
        if (hit) begin
          data <= ctl.value;
        end else if (above) begin
          data <= left_data;
        end
      end
      CELL_DEL: begin
        if (hit || above) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
    rd_data <= (ctl.op == CELL_READ && hit) ? data : '0;
  end

endmodule

// ===== design/plist_or_tree.sv =====
// Registered three-level OR tree that gathers the one selected cell entry.
module plist_or_tree import plist_pkg::*; #(
  parameter int N = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic [DATA_W-1:0] leaf [N],
  output logic [DATA_W-1:0] root
);

  localparam int GS = 8;
  localparam int G1 = (N + GS - 1) / GS;
  localparam int G2 = (G1 + GS - 1) / GS;

  logic [DATA_W-1:0] l1_c [G1];
  logic [DATA_W-1:0] l1   [G1];
  logic [DATA_W-1:0] l2_c [G2];
  logic [DATA_W-1:0] l2   [G2];
  logic [DATA_W-1:0] l3_c;

  always_comb begin
    for (int g = 0; g < G1; g++) begin
      l1_c[g] = '0;
    end
    for (int i = 0; i < N; i++) begin
      l1_c[i / GS] = l1_c[i / GS] | leaf[i];
    end
  end

  always_comb begin
    for (int g = 0; g < G2; g++) begin
      l2_c[g] = '0;
    end
    for (int i = 0; i < G1; i++) begin
      l2_c[i / GS] = l2_c[i / GS] | l1[i];
    end
  end

  always_comb begin
    l3_c = '0;
    for (int i = 0; i < G2; i++) begin
      l3_c = l3_c | l2[i];
    end
  end

  always_ff @(posedge clk) begin
    l1   <= l1_c;
    l2   <= l2_c;
    root <= l3_c;
  end

endmodule
